@@ src/afu_pkg.sv @@
// Shared types, constants and table builders for the activation function unit.
// Used by every module under src; depends on nothing.
`default_nettype none

package afu_pkg;

    // Interpolation grid and fixed-point constants
    localparam int TABLE_ENTRIES = 256;
    localparam int IDXW = $clog2(TABLE_ENTRIES + 1);
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic [30:0] ONE31 = 31'h4000_0000;
    localparam logic signed [31:0] TURN_PER_Q12 = 32'sd166886;
    localparam logic [17:0] LEAKY_RECIP = 18'd167773;   // ceil(2^24 / 100)
    localparam int EXP_POW_STAGES = 15;
    localparam int DIV_PAIR_STAGES = 15;

    typedef enum int {
        KIND_EXP,
        KIND_LN,
        KIND_SIN
    } afu_kind_t;

    typedef enum logic [4:0] {
        OP_IDENT     = 5'd0,
        OP_STEP      = 5'd1,
        OP_SIGMOID   = 5'd2,
        OP_TANH      = 5'd3,
        OP_RELU      = 5'd4,
        OP_LEAKY     = 5'd5,
        OP_SOFTPLUS  = 5'd6,
        OP_GAUSS     = 5'd7,
        OP_SINE      = 5'd8,
        OP_D_IDENT   = 5'd9,
        OP_D_STEP    = 5'd10,
        OP_D_SIGMOID = 5'd11,
        OP_D_TANH    = 5'd12,
        OP_D_RELU    = 5'd13,
        OP_D_LEAKY   = 5'd14,
        OP_D_SOFTPLUS = 5'd15,
        OP_D_GAUSS   = 5'd16,
        OP_D_SINE    = 5'd17
    } afu_op_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_18,
        SH_30
    } afu_shift_t;

    typedef logic [30:0] afu_val_t;
    typedef afu_val_t afu_tab_t [0:TABLE_ENTRIES];

    // Per-word context that rides along the pipeline
    typedef struct packed {
        logic [4:0]  op;
        logic        neg;     // x < 0
        logic        xpos;    // x > 0
        logic [15:0] mag_a;   // |x|
        logic [15:0] qdir;    // result of the simple ops, already in Q12
        logic        wneg;    // wave lands in the lower half
        logic [3:0]  ipow;    // integer part of the exp argument
        logic        ezero;   // exp argument of 16 or more
        afu_val_t    ev;      // exp or sine value, Q30
        afu_val_t    lnv;     // ln(1+e), Q30
    } afu_ctx_t;

    // Unsigned shift-and-subtract quotient, used only while building tables
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Grid point k of one table, Q30 series with truncating steps
    function automatic afu_val_t grid_value(afu_kind_t kind, int k);
        longint unsigned kk;
        longint unsigned p;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint sum;
        kk = (k > TABLE_ENTRIES) ? 64'(TABLE_ENTRIES) : 64'(k);
        sum = 0;
        case (kind)
            KIND_SIN:
            begin
                p = (kk * HALF_PI_Q30) / TABLE_ENTRIES;
                sum = longint'(p);
                term = p;
                for (int n = 1; n <= 10; n++)
                begin
                    term = (((term * p) >> 30) * p) >> 30;
                    term = udiv(term, 64'((2 * n) * (2 * n + 1)));
                    if ((n % 2) == 1) sum = sum - longint'(term);
                    else sum = sum + longint'(term);
                end
            end
            KIND_EXP:
            begin
                p = (kk << 30) / TABLE_ENTRIES;
                sum = longint'(ONE_Q30);
                term = ONE_Q30;
                for (int n = 1; n <= 20; n++)
                begin
                    term = udiv((term * p) >> 30, 64'(n));
                    if ((n % 2) == 1) sum = sum - longint'(term);
                    else sum = sum + longint'(term);
                end
            end
            default:
            begin
                p = (kk << 30) / TABLE_ENTRIES;
                z = udiv(p << 30, 2 * ONE_Q30 + p);
                z2 = (z * z) >> 30;
                sum = longint'(z);
                term = z;
                for (int n = 1; n <= 15; n++)
                begin
                    term = (term * z2) >> 30;
                    sum = sum + longint'(udiv(term, 64'(2 * n + 1)));
                end
                sum = 2 * sum;
            end
        endcase
        if (sum < 0) sum = 0;
        return afu_val_t'(sum);
    endfunction

    function automatic afu_tab_t build_table(afu_kind_t kind);
        afu_tab_t tab;
        for (int k = 0; k <= TABLE_ENTRIES; k++)
        begin
            tab[k] = grid_value(kind, k);
        end
        return tab;
    endfunction

    // e^-1 in Q30, the last exp grid point
    localparam afu_val_t EXP_ONE = grid_value(KIND_EXP, TABLE_ENTRIES);

    // One restoring division step: {new remainder, quotient bit}
    function automatic logic [32:0] div_step(logic [31:0] rem, logic [31:0] d);
        logic [32:0] r2;
        r2 = {rem, 1'b0};
        if (r2 >= {1'b0, d})
        begin
            r2 = r2 - {1'b0, d};
            return {r2[31:0], 1'b1};
        end
        return {r2[31:0], 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ src/afu_front.sv @@
// Input register and decode stage: magnitude, exp argument, wave phase, simple ops.
// Depends on afu_pkg.
`default_nettype none

module afu_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [4:0]         in_op,
    input  wire logic signed [15:0] in_x,
    output logic                    out_valid,
    output afu_pkg::afu_ctx_t       out_ctx,
    output logic                    out_sel,
    output logic [30:0]             out_r
);

    logic               v1_reg;
    logic [4:0]         op1_reg;
    logic signed [15:0] x1_reg;

    logic               neg;
    logic [15:0]        a;
    logic [31:0]        sq;
    logic [18:0]        tg;
    logic [18:0]        t;
    logic signed [31:0] xs;
    logic [31:0]        phase;
    logic [30:0]        r_sin;
    logic [9:0]         leaky;
    logic               is_wave;
    afu_pkg::afu_ctx_t  ctx_next;
    logic [30:0]        r_next;

    // Input word register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end
        else begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        op1_reg <= in_op;
        x1_reg  <= in_x;
    end

    // Decode
    always_comb begin
        neg = x1_reg[15];
        a = neg ? 16'(-x1_reg) : 16'(x1_reg);
        sq = 32'(a) * 32'(a);
        tg = 19'((sq + 32'd2048) >> 12);
        xs = 32'(x1_reg);
        phase = 32'(xs * afu_pkg::TURN_PER_Q12);
        if (op1_reg == afu_pkg::OP_D_SINE) phase = phase + 32'h4000_0000;
        r_sin = phase[30] ? (afu_pkg::ONE31 - 31'(phase[29:0])) : 31'(phase[29:0]);
        leaky = 10'(((34'(a) + 34'd50) * 34'(afu_pkg::LEAKY_RECIP)) >> 24);
        is_wave = (op1_reg == afu_pkg::OP_SINE) || (op1_reg == afu_pkg::OP_D_SINE);

        ctx_next = '0;
        ctx_next.op = op1_reg;
        ctx_next.neg = neg;
        ctx_next.xpos = !neg && (x1_reg != 16'sd0);
        ctx_next.mag_a = a;
        ctx_next.wneg = phase[31];

        t = '0;
        case (op1_reg)
            afu_pkg::OP_IDENT:      ctx_next.qdir = a;
            afu_pkg::OP_STEP:       ctx_next.qdir = neg ? 16'd0 : 16'd4096;
            afu_pkg::OP_SIGMOID:    t = 19'(a);
            afu_pkg::OP_TANH:       t = 19'({a, 1'b0});
            afu_pkg::OP_RELU:       ctx_next.qdir = neg ? 16'd0 : a;
            afu_pkg::OP_LEAKY:      ctx_next.qdir = ctx_next.xpos ? a : 16'(leaky);
            afu_pkg::OP_SOFTPLUS:   t = 19'(a);
            afu_pkg::OP_GAUSS:      t = tg;
            afu_pkg::OP_D_IDENT:    ctx_next.qdir = 16'd4096;
            afu_pkg::OP_D_SIGMOID:  t = 19'(a);
            afu_pkg::OP_D_TANH:     t = 19'({a, 1'b0});
            afu_pkg::OP_D_RELU:     ctx_next.qdir = ctx_next.xpos ? 16'd4096 : 16'd0;
            afu_pkg::OP_D_LEAKY:    ctx_next.qdir = ctx_next.xpos ? 16'd4096 : 16'd41;
            afu_pkg::OP_D_SOFTPLUS: t = 19'(a);
            afu_pkg::OP_D_GAUSS:    t = tg;
            default:                ctx_next.qdir = 16'd0;
        endcase
        ctx_next.ipow = t[15:12];
        ctx_next.ezero = |t[18:16];
        r_next = is_wave ? r_sin : {1'b0, t[11:0], 18'd0};
    end

    // Decoded word register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid <= 1'b0;
        end
        else begin
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        out_ctx <= ctx_next;
        out_sel <= is_wave;
        out_r   <= r_next;
    end

endmodule

`default_nettype wire

@@ src/afu_lookup.sv @@
// Three-stage interpolated table lookup over two constant tables.
// Depends on afu_pkg (table builder, grid size).
`default_nettype none

module afu_lookup #(
    parameter afu_pkg::afu_kind_t KIND_A = afu_pkg::KIND_EXP,
    parameter afu_pkg::afu_kind_t KIND_B = afu_pkg::KIND_SIN
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire afu_pkg::afu_ctx_t in_ctx,
    input  wire logic              in_sel,
    input  wire logic [30:0]       in_r,
    output logic                   out_valid,
    output afu_pkg::afu_ctx_t      out_ctx,
    output logic [30:0]            out_v
);

    localparam int POSW = 30 + afu_pkg::IDXW;
    localparam afu_pkg::afu_tab_t TAB_A = afu_pkg::build_table(KIND_A);
    localparam afu_pkg::afu_tab_t TAB_B = afu_pkg::build_table(KIND_B);

    logic [POSW-1:0]          pos;
    logic [afu_pkg::IDXW-1:0] idx_a;
    logic [afu_pkg::IDXW-1:0] idx_b;
    logic [30:0]              a_next;
    logic [30:0]              b_next;

    logic                     v1_reg;
    afu_pkg::afu_ctx_t        ctx1_reg;
    logic [30:0]              a1_reg;
    logic [30:0]              b1_reg;
    logic [29:0]              rem1_reg;

    logic                     up_next;
    logic [30:0]              diff;
    logic [60:0]              prod;

    logic                     v2_reg;
    afu_pkg::afu_ctx_t        ctx2_reg;
    logic [30:0]              a2_reg;
    logic [30:0]              step2_reg;
    logic                     up2_reg;

    // Grid position and table read
    always_comb begin
        pos = POSW'(in_r) * POSW'(afu_pkg::TABLE_ENTRIES);
        idx_a = pos[POSW-1:30];
        idx_b = (idx_a == afu_pkg::IDXW'(afu_pkg::TABLE_ENTRIES)) ? idx_a : idx_a + 1'b1;
        a_next = in_sel ? TAB_B[idx_a] : TAB_A[idx_a];
        b_next = in_sel ? TAB_B[idx_b] : TAB_A[idx_b];
    end

    // Slope times remainder
    always_comb begin
        up_next = b1_reg >= a1_reg;
        diff = up_next ? (b1_reg - a1_reg) : (a1_reg - b1_reg);
        prod = 61'(diff) * 61'(rem1_reg);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            out_valid <= v2_reg;
        end
    end

    always_ff @(posedge clk) begin
        ctx1_reg  <= in_ctx;
        a1_reg    <= a_next;
        b1_reg    <= b_next;
        rem1_reg  <= pos[29:0];
        ctx2_reg  <= ctx1_reg;
        a2_reg    <= a1_reg;
        step2_reg <= 31'(prod >> 30);
        up2_reg   <= up_next;
        out_ctx   <= ctx2_reg;
        out_v     <= up2_reg ? (a2_reg + step2_reg) : (a2_reg - step2_reg);
    end

endmodule

`default_nettype wire

@@ src/afu_exp_chain.sv @@
// Integer part of e^-t: one conditional multiply by e^-1 per stage.
// Depends on afu_pkg (EXP_ONE, stage count, context type).
`default_nettype none

module afu_exp_chain (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire afu_pkg::afu_ctx_t in_ctx,
    input  wire logic [30:0]       in_v,
    output logic                   out_valid,
    output afu_pkg::afu_ctx_t      out_ctx
);

    localparam int S = afu_pkg::EXP_POW_STAGES;

    logic [S-1:0]      valid_reg;
    afu_pkg::afu_ctx_t ctx_reg [0:S-1];
    logic [30:0]       v_reg [0:S-1];

    for (genvar j = 0; j < S; j++) begin : g_stage
        logic              vin;
        afu_pkg::afu_ctx_t cin;
        logic [30:0]       din;
        logic [61:0]       prod;
        logic [30:0]       v_next;

        if (j == 0) begin : g_first
            assign vin = in_valid;
            assign cin = in_ctx;
            assign din = in_v;
        end
        else begin : g_rest
            assign vin = valid_reg[j-1];
            assign cin = ctx_reg[j-1];
            assign din = v_reg[j-1];
        end

        // Multiply number j+1 happens only while the power lasts
        assign prod = 62'(din) * 62'(afu_pkg::EXP_ONE);
        assign v_next = (int'(cin.ipow) > j) ? 31'(prod >> 30) : din;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                valid_reg[j] <= 1'b0;
            end
            else begin
                valid_reg[j] <= vin;
            end
        end

        always_ff @(posedge clk) begin
            ctx_reg[j] <= cin;
            v_reg[j]   <= v_next;
        end
    end

    // Large arguments give zero
    always_comb begin
        out_ctx = ctx_reg[S-1];
        out_ctx.ev = ctx_reg[S-1].ezero ? 31'd0 : v_reg[S-1];
    end

    assign out_valid = valid_reg[S-1];

endmodule

`default_nettype wire

@@ src/afu_divider.sv @@
// Pipelined restoring divider: (num << 30) / (2^30 + e), two quotient bits per stage.
// Depends on afu_pkg (div_step, stage count, context type).
`default_nettype none

module afu_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire afu_pkg::afu_ctx_t in_ctx,
    input  wire logic [30:0]       in_num,
    output logic                   out_valid,
    output afu_pkg::afu_ctx_t      out_ctx,
    output logic [30:0]            out_q
);

    localparam int S = afu_pkg::DIV_PAIR_STAGES;

    logic [31:0]       d0;
    logic              ge0;

    logic              v0_reg;
    afu_pkg::afu_ctx_t ctx0_reg;
    logic [31:0]       d0_reg;
    logic [31:0]       rem0_reg;
    logic [30:0]       q0_reg;

    logic [S-1:0]      valid_reg;
    afu_pkg::afu_ctx_t ctx_reg [0:S-1];
    logic [31:0]       d_reg [0:S-1];
    logic [31:0]       rem_reg [0:S-1];
    logic [30:0]       q_reg [0:S-1];

    // Top quotient bit
    assign d0  = 32'(afu_pkg::ONE31) + 32'(in_ctx.ev);
    assign ge0 = 32'(in_num) >= d0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
        end
        else begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        ctx0_reg <= in_ctx;
        d0_reg   <= d0;
        rem0_reg <= ge0 ? (32'(in_num) - d0) : 32'(in_num);
        q0_reg   <= 31'(ge0);
    end

    for (genvar j = 0; j < S; j++) begin : g_stage
        logic              vin;
        afu_pkg::afu_ctx_t cin;
        logic [31:0]       din;
        logic [31:0]       rin;
        logic [30:0]       qin;
        logic [32:0]       s1;
        logic [32:0]       s2;

        if (j == 0) begin : g_first
            assign vin = v0_reg;
            assign cin = ctx0_reg;
            assign din = d0_reg;
            assign rin = rem0_reg;
            assign qin = q0_reg;
        end
        else begin : g_rest
            assign vin = valid_reg[j-1];
            assign cin = ctx_reg[j-1];
            assign din = d_reg[j-1];
            assign rin = rem_reg[j-1];
            assign qin = q_reg[j-1];
        end

        // Two shift-subtract steps
        assign s1 = afu_pkg::div_step(rin, din);
        assign s2 = afu_pkg::div_step(s1[32:1], din);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                valid_reg[j] <= 1'b0;
            end
            else begin
                valid_reg[j] <= vin;
            end
        end

        always_ff @(posedge clk) begin
            ctx_reg[j] <= cin;
            d_reg[j]   <= din;
            rem_reg[j] <= s2[32:1];
            q_reg[j]   <= {qin[28:0], s1[0], s2[0]};
        end
    end

    assign out_valid = valid_reg[S-1];
    assign out_ctx   = ctx_reg[S-1];
    assign out_q     = q_reg[S-1];

endmodule

`default_nettype wire

@@ src/afu_back.sv @@
// Output stages: per-op product and magnitude select, then round, saturate and negate.
// Depends on afu_pkg (opcodes, shift codes, context type).
`default_nettype none

module afu_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire afu_pkg::afu_ctx_t in_ctx,
    input  wire logic [30:0]       in_s,
    output logic                   done,
    output logic signed [15:0]     value,
    output logic                   saturated
);

    logic [61:0]          p_sig;
    logic [61:0]          p_sq;
    logic [47:0]          p_gau;
    logic [47:0]          mag_next;
    afu_pkg::afu_shift_t  sh_next;
    logic                 neg_next;

    logic                 v_reg;
    logic [47:0]          mag_reg;
    afu_pkg::afu_shift_t  sh_reg;
    logic                 neg_reg;

    logic [30:0]          q;
    logic [15:0]          qc;
    logic                 sat_next;

    // Magnitude select
    always_comb begin
        p_sig = 62'(in_s) * 62'(afu_pkg::ONE31 - in_s);
        p_sq  = 62'(in_s) * 62'(in_s);
        p_gau = 48'(in_ctx.mag_a) * 48'(in_ctx.ev);
        mag_next = 48'(in_ctx.qdir);
        sh_next = afu_pkg::SH_NONE;
        neg_next = 1'b0;
        case (in_ctx.op)
            afu_pkg::OP_IDENT: begin
                neg_next = in_ctx.neg;
            end
            afu_pkg::OP_LEAKY: begin
                neg_next = !in_ctx.xpos;
            end
            afu_pkg::OP_SIGMOID, afu_pkg::OP_D_SOFTPLUS: begin
                mag_next = 48'(in_s);
                sh_next = afu_pkg::SH_18;
            end
            afu_pkg::OP_TANH: begin
                mag_next = 48'(in_s);
                sh_next = afu_pkg::SH_18;
                neg_next = in_ctx.neg;
            end
            afu_pkg::OP_D_SIGMOID: begin
                mag_next = 48'(p_sig >> 30);
                sh_next = afu_pkg::SH_18;
            end
            afu_pkg::OP_D_TANH: begin
                mag_next = 48'(afu_pkg::ONE31) - 48'(p_sq >> 30);
                sh_next = afu_pkg::SH_18;
            end
            afu_pkg::OP_SOFTPLUS: begin
                mag_next = 48'(in_ctx.lnv) + (in_ctx.neg ? 48'd0 : (48'(in_ctx.mag_a) << 18));
                sh_next = afu_pkg::SH_18;
            end
            afu_pkg::OP_GAUSS: begin
                mag_next = 48'(in_ctx.ev);
                sh_next = afu_pkg::SH_18;
            end
            afu_pkg::OP_SINE, afu_pkg::OP_D_SINE: begin
                mag_next = 48'(in_ctx.ev);
                sh_next = afu_pkg::SH_18;
                neg_next = in_ctx.wneg;
            end
            afu_pkg::OP_D_GAUSS: begin
                mag_next = p_gau << 1;
                sh_next = afu_pkg::SH_30;
                neg_next = in_ctx.xpos;
            end
            default: begin
                mag_next = 48'(in_ctx.qdir);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= 1'b0;
            done  <= 1'b0;
        end
        else begin
            v_reg <= in_valid;
            done  <= v_reg;
        end
    end

    always_ff @(posedge clk) begin
        mag_reg <= mag_next;
        sh_reg  <= sh_next;
        neg_reg <= neg_next;
    end

    // Round half away from zero, then clamp to Q4.12
    always_comb begin
        case (sh_reg)
            afu_pkg::SH_18: q = 31'((49'(mag_reg) + 49'h2_0000) >> 18);
            afu_pkg::SH_30: q = 31'((49'(mag_reg) + 49'h2000_0000) >> 30);
            default:        q = 31'(mag_reg);
        endcase
        sat_next = 1'b0;
        if (neg_reg) begin
            if (q > 31'd32768) begin
                qc = 16'h8000;
                sat_next = 1'b1;
            end
            else begin
                qc = 16'(q);
            end
            qc = 16'(-qc);
        end
        else begin
            if (q > 31'd32767) begin
                qc = 16'h7fff;
                sat_next = 1'b1;
            end
            else begin
                qc = 16'(q);
            end
        end
    end

    always_ff @(posedge clk) begin
        value     <= signed'(qc);
        saturated <= sat_next;
    end

endmodule

`default_nettype wire

@@ src/activation_function_unit.sv @@
// Top level of the activation function unit: decode, two table lookups, exp power
// chain, divider and output stage. Depends on afu_pkg and all afu_* modules.
//
// One word (opcode, Q4.12 sample) may be started in every clock cycle; busy is
// always low. Each result appears on value/saturated with done high for one cycle.
// The pipeline has 2 decode stages, 3 per table lookup (two lookups), 15 stages of
// e^-1 multiplies for the integer part of the exp argument, 16 divider stages and
// 2 output stages. The receiver cannot stall the block and results are never held.
`default_nettype none

module activation_function_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [4:0]         opcode,
    input  wire logic signed [15:0] sample,
    output logic                    done,
    output logic signed [15:0]      value,
    output logic                    saturated
);

    logic              fr_valid;
    afu_pkg::afu_ctx_t fr_ctx;
    logic              fr_sel;
    logic [30:0]       fr_r;

    logic              la_valid;
    afu_pkg::afu_ctx_t la_ctx;
    logic [30:0]       la_v;

    logic              ex_valid;
    afu_pkg::afu_ctx_t ex_ctx;

    logic              lb_valid;
    afu_pkg::afu_ctx_t lb_ctx;
    logic [30:0]       lb_v;

    afu_pkg::afu_ctx_t dv_in_ctx;
    logic [30:0]       dv_num;

    logic              dv_valid;
    afu_pkg::afu_ctx_t dv_ctx;
    logic [30:0]       dv_q;

    assign busy = 1'b0;

    afu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_op     (opcode),
        .in_x      (sample),
        .out_valid (fr_valid),
        .out_ctx   (fr_ctx),
        .out_sel   (fr_sel),
        .out_r     (fr_r)
    );

    // Fraction of e^-t, or the quarter-wave sine
    afu_lookup #(
        .KIND_A (afu_pkg::KIND_EXP),
        .KIND_B (afu_pkg::KIND_SIN)
    ) u_lookup_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ctx    (fr_ctx),
        .in_sel    (fr_sel),
        .in_r      (fr_r),
        .out_valid (la_valid),
        .out_ctx   (la_ctx),
        .out_v     (la_v)
    );

    afu_exp_chain u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (la_valid),
        .in_ctx    (la_ctx),
        .in_v      (la_v),
        .out_valid (ex_valid),
        .out_ctx   (ex_ctx)
    );

    // ln(1 + e) for softplus
    afu_lookup #(
        .KIND_A (afu_pkg::KIND_LN),
        .KIND_B (afu_pkg::KIND_LN)
    ) u_lookup_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ex_valid),
        .in_ctx    (ex_ctx),
        .in_sel    (1'b0),
        .in_r      (ex_ctx.ev),
        .out_valid (lb_valid),
        .out_ctx   (lb_ctx),
        .out_v     (lb_v)
    );

    // Dividend for sigmoid and tanh, their derivatives and the softplus derivative
    always_comb begin
        dv_in_ctx = lb_ctx;
        dv_in_ctx.lnv = lb_v;
        case (lb_ctx.op)
            afu_pkg::OP_SIGMOID, afu_pkg::OP_D_SIGMOID, afu_pkg::OP_D_SOFTPLUS:
                dv_num = lb_ctx.neg ? lb_ctx.ev : afu_pkg::ONE31;
            afu_pkg::OP_TANH, afu_pkg::OP_D_TANH:
                dv_num = afu_pkg::ONE31 - lb_ctx.ev;
            default:
                dv_num = 31'd0;
        endcase
    end

    afu_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lb_valid),
        .in_ctx    (dv_in_ctx),
        .in_num    (dv_num),
        .out_valid (dv_valid),
        .out_ctx   (dv_ctx),
        .out_q     (dv_q)
    );

    afu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ctx    (dv_ctx),
        .in_s      (dv_q),
        .done      (done),
        .value     (value),
        .saturated (saturated)
    );

endmodule

`default_nettype wire
